// File: rtl/ehd_pkg.sv
// Shared types and constants of the edge hit distance block.
package ehd_pkg;

	localparam int COORD_FRAC_BITS = 4;
	localparam int COORD_W = 16;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SQ_W = 34;
	localparam int QUO_W = 33;
	localparam int ROOT_W = SQ_W / 2;
	localparam int SREM_W = ROOT_W + 3;
	localparam int DIST_W = 17;
	localparam int THR_W = 16;
	localparam int IN_DATA_W = 8 * COORD_W;
	localparam int OUT_DATA_W = 24;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(10 << COORD_FRAC_BITS);
	localparam logic REG_HIT_THRESHOLD = 1'b0;

	typedef enum logic [1:0] {
		MODE_POINT,
		MODE_PERP,
		MODE_ARC
	} mode_t;

	typedef struct packed {
		mode_t           mode;
		logic [SQ_W-1:0] a;
		logic [SQ_W-1:0] b;
	} ctx_t;

endpackage

// File: rtl/edge_hit_distance_top.sv
// Top level of the edge hit distance block: stream ports, threshold register, pipeline.
//
//  channel   | dir | handshake          | payload
//  s_*       | in  | s_tvalid/s_tready  | s_tdata: 8 coordinates, s_tuser: edge kind
//  m_*       | out | m_tvalid/m_tready  | m_tdata: distance, hit
//  APB       | in  | psel/penable/pready| hit_threshold at byte address 0
//
// One word is taken every cycle unless the output word is held. There are 4 front
// stages, 2 product stages and 33 quotient stages of the divider plus its output
// stage, 17 root stages, and 5 correction stages, the 33-bit quotient recurrence
// making the divider deepest. Reset clears all valid bits and loads the threshold
// with 10 pixels. A held output word holds the whole pipeline and drops s_tready.
module edge_hit_distance_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// point_x, point_y, start_x, start_y, end_x, end_y, center_x, center_y
	input  logic [ehd_pkg::IN_DATA_W-1:0]      s_tdata,
	// kind
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// distance [16:0], hit [17], zero pad [23:18]
	output logic [ehd_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ehd_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [ehd_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [ehd_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);
	import ehd_pkg::*;

	logic en;
	logic [THR_W-1:0] thr_q;

	logic            fr_valid;
	mode_t           fr_mode;
	logic [SQ_W-1:0] fr_x, fr_y, fr_b;

	logic            dv_valid;
	ctx_t            dv_ctx;
	logic [SQ_W-1:0] dv_rad;

	logic              sq_valid;
	ctx_t              sq_ctx;
	logic [ROOT_W-1:0] sq_root1, sq_root2;
	logic              sq_rem1_nz;

	logic              fx_valid;
	logic [DIST_W-1:0] fx_dist;
	logic              fx_hit;

	// All stages advance together; the last stage is the output register.
	assign en       = !fx_valid || m_tready;
	assign s_tready = en;

	// Register file: the only register is the hit threshold.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[APB_ADDR_W-1] == REG_HIT_THRESHOLD) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	assign prdata = (paddr[APB_ADDR_W-1] == REG_HIT_THRESHOLD)
		? APB_DATA_W'(thr_q) : '0;

	logic unused_addr;
	assign unused_addr = ^{paddr[APB_ADDR_W-2:0], pwdata[APB_DATA_W-1:THR_W]};

	ehd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.kind     (s_tuser),
		.point_x  (s_tdata[0*COORD_W +: COORD_W]),
		.point_y  (s_tdata[1*COORD_W +: COORD_W]),
		.start_x  (s_tdata[2*COORD_W +: COORD_W]),
		.start_y  (s_tdata[3*COORD_W +: COORD_W]),
		.end_x    (s_tdata[4*COORD_W +: COORD_W]),
		.end_y    (s_tdata[5*COORD_W +: COORD_W]),
		.center_x (s_tdata[6*COORD_W +: COORD_W]),
		.center_y (s_tdata[7*COORD_W +: COORD_W]),
		.out_valid(fr_valid),
		.out_mode (fr_mode),
		.out_x    (fr_x),
		.out_y    (fr_y),
		.out_b    (fr_b)
	);

	ehd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fr_valid),
		.in_mode  (fr_mode),
		.in_x     (fr_x),
		.in_y     (fr_y),
		.in_b     (fr_b),
		.out_valid(dv_valid),
		.out_ctx  (dv_ctx),
		.out_rad  (dv_rad)
	);

	ehd_sqrt u_sqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (dv_valid),
		.in_ctx     (dv_ctx),
		.in_rad     (dv_rad),
		.out_valid  (sq_valid),
		.out_ctx    (sq_ctx),
		.out_root1  (sq_root1),
		.out_rem1_nz(sq_rem1_nz),
		.out_root2  (sq_root2)
	);

	ehd_fix u_fix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid),
		.in_ctx   (sq_ctx),
		.root1    (sq_root1),
		.rem1_nz  (sq_rem1_nz),
		.root2    (sq_root2),
		.thr      (thr_q),
		.out_valid(fx_valid),
		.out_dist (fx_dist),
		.out_hit  (fx_hit)
	);

	assign m_tvalid = fx_valid;
	assign m_tdata  = {(OUT_DATA_W - DIST_W - 1)'(0), fx_hit, fx_dist};

endmodule

// File: rtl/ehd_front.sv
// Front end: coordinate differences, products and choice of the distance form.
module ehd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic                              kind,
	input  logic signed [ehd_pkg::COORD_W-1:0] point_x,
	input  logic signed [ehd_pkg::COORD_W-1:0] point_y,
	input  logic signed [ehd_pkg::COORD_W-1:0] start_x,
	input  logic signed [ehd_pkg::COORD_W-1:0] start_y,
	input  logic signed [ehd_pkg::COORD_W-1:0] end_x,
	input  logic signed [ehd_pkg::COORD_W-1:0] end_y,
	input  logic signed [ehd_pkg::COORD_W-1:0] center_x,
	input  logic signed [ehd_pkg::COORD_W-1:0] center_y,
	output logic                              out_valid,
	output ehd_pkg::mode_t                    out_mode,
	output logic [ehd_pkg::SQ_W-1:0]          out_x,
	output logic [ehd_pkg::SQ_W-1:0]          out_y,
	output logic [ehd_pkg::SQ_W-1:0]          out_b
);
	import ehd_pkg::*;

	function automatic logic signed [DIFF_W-1:0] sub_ext(
		input logic signed [COORD_W-1:0] u,
		input logic signed [COORD_W-1:0] v
	);
		sub_ext = $signed({u[COORD_W-1], u}) - $signed({v[COORD_W-1], v});
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic kind_s1, kind_s2, kind_s3;
	logic signed [DIFF_W-1:0] abx_s1, aby_s1, apx_s1, apy_s1, pex_s1, pey_s1;
	logic signed [DIFF_W-1:0] pcx_s1, pcy_s1, scx_s1, scy_s1;
	logic signed [PROD_W-1:0] abxx_s2, abyy_s2, apxx_s2, apyy_s2, pexx_s2, peyy_s2;
	logic signed [PROD_W-1:0] pcxx_s2, pcyy_s2, scxx_s2, scyy_s2;
	logic signed [PROD_W-1:0] dotx_s2, doty_s2, crx_s2, cry_s2;
	logic [SQ_W-1:0] ab2_s3, ap2_s3, pe2_s3, pc2_s3, sc2_s3;
	logic signed [PROD_W:0] dot_s3, cr_s3;
	mode_t mode_s4;
	logic [SQ_W-1:0] x_s4, y_s4, b_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind;
			abx_s1  <= sub_ext(end_x, start_x);
			aby_s1  <= sub_ext(end_y, start_y);
			apx_s1  <= sub_ext(point_x, start_x);
			apy_s1  <= sub_ext(point_y, start_y);
			pex_s1  <= sub_ext(point_x, end_x);
			pey_s1  <= sub_ext(point_y, end_y);
			pcx_s1  <= sub_ext(point_x, center_x);
			pcy_s1  <= sub_ext(point_y, center_y);
			scx_s1  <= sub_ext(start_x, center_x);
			scy_s1  <= sub_ext(start_y, center_y);

			kind_s2 <= kind_s1;
			abxx_s2 <= abx_s1 * abx_s1;
			abyy_s2 <= aby_s1 * aby_s1;
			apxx_s2 <= apx_s1 * apx_s1;
			apyy_s2 <= apy_s1 * apy_s1;
			pexx_s2 <= pex_s1 * pex_s1;
			peyy_s2 <= pey_s1 * pey_s1;
			pcxx_s2 <= pcx_s1 * pcx_s1;
			pcyy_s2 <= pcy_s1 * pcy_s1;
			scxx_s2 <= scx_s1 * scx_s1;
			scyy_s2 <= scy_s1 * scy_s1;
			dotx_s2 <= apx_s1 * abx_s1;
			doty_s2 <= apy_s1 * aby_s1;
			crx_s2  <= abx_s1 * apy_s1;
			cry_s2  <= aby_s1 * apx_s1;

			// Squares are nonnegative and their sums stay below 2^33.
			kind_s3 <= kind_s2;
			ab2_s3  <= SQ_W'(abxx_s2 + abyy_s2);
			ap2_s3  <= SQ_W'(apxx_s2 + apyy_s2);
			pe2_s3  <= SQ_W'(pexx_s2 + peyy_s2);
			pc2_s3  <= SQ_W'(pcxx_s2 + pcyy_s2);
			sc2_s3  <= SQ_W'(scxx_s2 + scyy_s2);
			dot_s3  <= $signed({dotx_s2[PROD_W-1], dotx_s2})
				+ $signed({doty_s2[PROD_W-1], doty_s2});
			cr_s3   <= $signed({crx_s2[PROD_W-1], crx_s2})
				- $signed({cry_s2[PROD_W-1], cry_s2});

			if (kind_s3) begin
				mode_s4 <= MODE_ARC;
				x_s4    <= (pc2_s3 >= sc2_s3) ? pc2_s3 : sc2_s3;
				y_s4    <= '0;
				b_s4    <= (pc2_s3 >= sc2_s3) ? sc2_s3 : pc2_s3;
			end else if (dot_s3[PROD_W] || dot_s3 == '0) begin
				mode_s4 <= MODE_POINT;
				x_s4    <= ap2_s3;
				y_s4    <= '0;
				b_s4    <= '0;
			end else if (dot_s3 >= $signed({1'b0, ab2_s3})) begin
				mode_s4 <= MODE_POINT;
				x_s4    <= pe2_s3;
				y_s4    <= '0;
				b_s4    <= '0;
			end else begin
				mode_s4 <= MODE_PERP;
				x_s4    <= ab2_s3;
				y_s4    <= SQ_W'(cr_s3[PROD_W] ? -cr_s3 : cr_s3);
				b_s4    <= '0;
			end
		end
	end

	assign out_valid = vld_s4;
	assign out_mode  = mode_s4;
	assign out_x     = x_s4;
	assign out_y     = y_s4;
	assign out_b     = b_s4;

endmodule

// File: rtl/ehd_div.sv
// Pipelined restoring divider: ceiling of the squared cross product over the squared length.
module ehd_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  ehd_pkg::mode_t           in_mode,
	input  logic [ehd_pkg::SQ_W-1:0] in_x,
	input  logic [ehd_pkg::SQ_W-1:0] in_y,
	input  logic [ehd_pkg::SQ_W-1:0] in_b,
	output logic                     out_valid,
	output ehd_pkg::ctx_t            out_ctx,
	output logic [ehd_pkg::SQ_W-1:0] out_rad
);
	import ehd_pkg::*;

	localparam int HALF_W = SQ_W / 2;
	localparam int NUM_W = 2 * SQ_W;

	logic vld_p1, vld_p2, vld_o;
	ctx_t ctx_p1, ctx_p2, ctx_o;
	logic [SQ_W-1:0] phh_p1, phl_p1, pll_p1;
	logic [NUM_W-1:0] num_p2;
	logic [SQ_W-1:0] rad_o;

	logic            vld_s [0:QUO_W-1];
	ctx_t            ctx_s [0:QUO_W-1];
	logic [SQ_W-1:0] rem_s [0:QUO_W-1];
	logic [QUO_W-1:0] dvd_s [0:QUO_W-1];
	logic [QUO_W-1:0] quo_s [0:QUO_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1 <= 1'b0;
			vld_p2 <= 1'b0;
		end else if (en) begin
			vld_p1 <= in_valid;
			vld_p2 <= vld_p1;
		end
	end

	// The square of the cross product is built from 17-bit halves.
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_p1 <= '{mode: in_mode, a: in_x, b: in_b};
			phh_p1 <= SQ_W'(in_y[SQ_W-1:HALF_W]) * SQ_W'(in_y[SQ_W-1:HALF_W]);
			phl_p1 <= SQ_W'(in_y[SQ_W-1:HALF_W]) * SQ_W'(in_y[HALF_W-1:0]);
			pll_p1 <= SQ_W'(in_y[HALF_W-1:0]) * SQ_W'(in_y[HALF_W-1:0]);
			ctx_p2 <= ctx_p1;
			num_p2 <= {phh_p1, {SQ_W{1'b0}}} + (NUM_W'(phl_p1) << (HALF_W + 1))
				+ NUM_W'(pll_p1);
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic             v_in;
		ctx_t             c_in;
		logic [SQ_W-1:0]  r_in;
		logic [QUO_W-1:0] d_in;
		logic [QUO_W-1:0] q_in;
		logic [SQ_W:0]    trial;
		logic             ge;

		if (k == 0) begin : g_first
			// The quotient stays below 2^33, so the top part is already below the divisor.
			assign v_in = vld_p2;
			assign c_in = ctx_p2;
			assign r_in = num_p2[NUM_W-2:QUO_W];
			assign d_in = num_p2[QUO_W-1:0];
			assign q_in = '0;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign c_in = ctx_s[k-1];
			assign r_in = rem_s[k-1];
			assign d_in = dvd_s[k-1];
			assign q_in = quo_s[k-1];
		end

		assign trial = {r_in, d_in[QUO_W-1]};
		assign ge    = trial >= {1'b0, c_in.a};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[k] <= c_in;
				rem_s[k] <= ge ? SQ_W'(trial - {1'b0, c_in.a}) : trial[SQ_W-1:0];
				dvd_s[k] <= {d_in[QUO_W-2:0], 1'b0};
				quo_s[k] <= {q_in[QUO_W-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_s[QUO_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_o <= ctx_s[QUO_W-1];
			if (ctx_s[QUO_W-1].mode == MODE_PERP) begin
				rad_o <= SQ_W'(quo_s[QUO_W-1]) + SQ_W'(rem_s[QUO_W-1] != '0);
			end else begin
				rad_o <= ctx_s[QUO_W-1].a;
			end
		end
	end

	assign out_valid = vld_o;
	assign out_ctx   = ctx_o;
	assign out_rad   = rad_o;

endmodule

// File: rtl/ehd_sqrt.sv
// Two-lane pipelined digit-by-digit square root, one root bit per stage.
module ehd_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  ehd_pkg::ctx_t              in_ctx,
	input  logic [ehd_pkg::SQ_W-1:0]   in_rad,
	output logic                       out_valid,
	output ehd_pkg::ctx_t              out_ctx,
	output logic [ehd_pkg::ROOT_W-1:0] out_root1,
	output logic                       out_rem1_nz,
	output logic [ehd_pkg::ROOT_W-1:0] out_root2
);
	import ehd_pkg::*;

	logic              vld_s  [0:ROOT_W-1];
	ctx_t              ctx_s  [0:ROOT_W-1];
	logic [SREM_W-1:0] rem1_s [0:ROOT_W-1];
	logic [SREM_W-1:0] rem2_s [0:ROOT_W-1];
	logic [ROOT_W-1:0] root1_s [0:ROOT_W-1];
	logic [ROOT_W-1:0] root2_s [0:ROOT_W-1];
	logic [SQ_W-1:0]   rad1_s [0:ROOT_W-1];
	logic [SQ_W-1:0]   rad2_s [0:ROOT_W-1];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic              v_in;
		ctx_t              c_in;
		logic [SREM_W-1:0] r1_in, r2_in, r1_sh, r2_sh;
		logic [ROOT_W-1:0] q1_in, q2_in;
		logic [SQ_W-1:0]   d1_in, d2_in;
		logic [ROOT_W+1:0] t1, t2;
		logic              ge1, ge2;

		if (k == 0) begin : g_first
			// Lane 1 takes the main radicand, lane 2 the smaller arc square.
			assign v_in  = in_valid;
			assign c_in  = in_ctx;
			assign r1_in = '0;
			assign r2_in = '0;
			assign q1_in = '0;
			assign q2_in = '0;
			assign d1_in = in_rad;
			assign d2_in = in_ctx.b;
		end else begin : g_next
			assign v_in  = vld_s[k-1];
			assign c_in  = ctx_s[k-1];
			assign r1_in = rem1_s[k-1];
			assign r2_in = rem2_s[k-1];
			assign q1_in = root1_s[k-1];
			assign q2_in = root2_s[k-1];
			assign d1_in = rad1_s[k-1];
			assign d2_in = rad2_s[k-1];
		end

		assign r1_sh = {r1_in[SREM_W-3:0], d1_in[SQ_W-1:SQ_W-2]};
		assign r2_sh = {r2_in[SREM_W-3:0], d2_in[SQ_W-1:SQ_W-2]};
		assign t1    = {q1_in, 2'b01};
		assign t2    = {q2_in, 2'b01};
		assign ge1   = r1_sh >= {1'b0, t1};
		assign ge2   = r2_sh >= {1'b0, t2};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[k]   <= c_in;
				rem1_s[k]  <= ge1 ? r1_sh - {1'b0, t1} : r1_sh;
				rem2_s[k]  <= ge2 ? r2_sh - {1'b0, t2} : r2_sh;
				root1_s[k] <= {q1_in[ROOT_W-2:0], ge1};
				root2_s[k] <= {q2_in[ROOT_W-2:0], ge2};
				rad1_s[k]  <= {d1_in[SQ_W-3:0], 2'b00};
				rad2_s[k]  <= {d2_in[SQ_W-3:0], 2'b00};
			end
		end
	end

	assign out_valid   = vld_s[ROOT_W-1];
	assign out_ctx     = ctx_s[ROOT_W-1];
	assign out_root1   = root1_s[ROOT_W-1];
	assign out_rem1_nz = rem1_s[ROOT_W-1] != '0;
	assign out_root2   = root2_s[ROOT_W-1];

endmodule

// File: rtl/ehd_fix.sv
// Final stages: arc ceiling correction, saturation and the hit compare.
module ehd_fix (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  ehd_pkg::ctx_t              in_ctx,
	input  logic [ehd_pkg::ROOT_W-1:0] root1,
	input  logic                       rem1_nz,
	input  logic [ehd_pkg::ROOT_W-1:0] root2,
	input  logic [ehd_pkg::THR_W-1:0]  thr,
	output logic                       out_valid,
	output logic [ehd_pkg::DIST_W-1:0] out_dist,
	output logic                       out_hit
);
	import ehd_pkg::*;

	localparam int HALF_W = SQ_W / 2;
	localparam int WIDE_W = 2 * SQ_W;
	localparam int L_W = SQ_W + 2;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4;
	logic [ROOT_W:0] d_s1, d_s2, d_s3, d_s4;
	logic [ROOT_W-1:0] q_s1, q_s2, q_s3, q_s4;
	logic [SQ_W-1:0] q2_s2;
	logic signed [L_W-1:0] l_s3, l_s4;
	logic [SQ_W-1:0] mhh_s3, mhl_s3, mlh_s3, mll_s3;
	logic [WIDE_W-1:0] q2b_s4;
	logic [SQ_W-1:0] lhh_s4, lhl_s4, lll_s4;
	logic [DIST_W-1:0] dist_s5;
	logic hit_s5;

	logic [ROOT_W:0] ca_c;
	logic [ROOT_W:0] d_c;
	logic lpos_c;
	logic [WIDE_W-1:0] l2_c;
	logic ok_c;
	logic [ROOT_W:0] res_c;
	logic [DIST_W-1:0] dist_c;

	assign ca_c = {1'b0, root1} + (ROOT_W+1)'(rem1_nz);
	assign d_c  = ca_c - {1'b0, root2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// For an arc the ceiling of the root difference is either d - 1 or d, with
	// d the ceiling of the outer root less the floor of the inner one; q = d - 1
	// is tested by comparing (a - b - q^2)^2 with 4 q^2 b.
	assign lpos_c = !l_s4[L_W-1] && (l_s4 != '0);
	assign l2_c   = {lhh_s4, {SQ_W{1'b0}}} + (WIDE_W'(lhl_s4) << (HALF_W + 1))
		+ WIDE_W'(lll_s4);
	assign ok_c   = !lpos_c || ({2'b00, l2_c} <= {q2b_s4, 2'b00});

	always_comb begin
		if (ctx_s4.mode != MODE_ARC) begin
			res_c = d_s4;
		end else if (d_s4 == '0) begin
			res_c = '0;
		end else if (ok_c) begin
			res_c = {1'b0, q_s4};
		end else begin
			res_c = d_s4;
		end
		dist_c = res_c[ROOT_W] ? {DIST_W{1'b1}} : res_c[DIST_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= in_ctx;
			d_s1   <= (in_ctx.mode == MODE_ARC) ? d_c : ca_c;
			q_s1   <= ROOT_W'(d_c - 1'b1);

			ctx_s2 <= ctx_s1;
			d_s2   <= d_s1;
			q_s2   <= q_s1;
			q2_s2  <= SQ_W'(q_s1) * SQ_W'(q_s1);

			ctx_s3 <= ctx_s2;
			d_s3   <= d_s2;
			q_s3   <= q_s2;
			l_s3   <= $signed({2'b00, ctx_s2.a}) - $signed({2'b00, ctx_s2.b})
				- $signed({2'b00, q2_s2});
			mhh_s3 <= SQ_W'(q2_s2[SQ_W-1:HALF_W]) * SQ_W'(ctx_s2.b[SQ_W-1:HALF_W]);
			mhl_s3 <= SQ_W'(q2_s2[SQ_W-1:HALF_W]) * SQ_W'(ctx_s2.b[HALF_W-1:0]);
			mlh_s3 <= SQ_W'(q2_s2[HALF_W-1:0]) * SQ_W'(ctx_s2.b[SQ_W-1:HALF_W]);
			mll_s3 <= SQ_W'(q2_s2[HALF_W-1:0]) * SQ_W'(ctx_s2.b[HALF_W-1:0]);

			ctx_s4 <= ctx_s3;
			d_s4   <= d_s3;
			q_s4   <= q_s3;
			l_s4   <= l_s3;
			q2b_s4 <= {mhh_s3, {SQ_W{1'b0}}} + (WIDE_W'(mhl_s3) << HALF_W)
				+ (WIDE_W'(mlh_s3) << HALF_W) + WIDE_W'(mll_s3);
			lhh_s4 <= SQ_W'(l_s3[SQ_W-1:HALF_W]) * SQ_W'(l_s3[SQ_W-1:HALF_W]);
			lhl_s4 <= SQ_W'(l_s3[SQ_W-1:HALF_W]) * SQ_W'(l_s3[HALF_W-1:0]);
			lll_s4 <= SQ_W'(l_s3[HALF_W-1:0]) * SQ_W'(l_s3[HALF_W-1:0]);

			dist_s5 <= dist_c;
			hit_s5  <= dist_c <= {1'b0, thr};
		end
	end

	assign out_valid = vld_s5;
	assign out_dist  = dist_s5;
	assign out_hit   = hit_s5;

endmodule

// File: rtl/ehd_checker.sv
// Port-level checker of the edge hit distance block, bound to the top level.
module ehd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [ehd_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ehd_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           psel,
	input logic                           penable,
	input logic                           pwrite,
	input logic [ehd_pkg::APB_ADDR_W-1:0] paddr,
	input logic [ehd_pkg::APB_DATA_W-1:0] pwdata,
	input logic [ehd_pkg::APB_DATA_W-1:0] prdata,
	input logic                           pready
);
	import ehd_pkg::*;

	logic [THR_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[APB_ADDR_W-1] == REG_HIT_THRESHOLD) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	logic unused_in;
	assign unused_in = ^{s_tvalid, s_tdata, s_tuser};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output word changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow the output stall");

	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[DIST_W] == (m_tdata[DIST_W-1:0] <= {1'b0, thr_q}))
		else $error("hit flag disagrees with distance and threshold");

	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && paddr[APB_ADDR_W-1] == REG_HIT_THRESHOLD
		|-> prdata == APB_DATA_W'(thr_q))
		else $error("threshold readback mismatch");

endmodule

bind edge_hit_distance_top ehd_checker u_ehd_checker (.*);

// File: tb/sv/tb_edge_hit_distance_top.sv
// Testbench of the edge hit distance block: directed table, random edges, scoreboard.
`timescale 1ns / 100ps

module tb_edge_hit_distance_top;
	import ehd_pkg::*;

	// Byte addresses of the APB registers. Only the threshold exists; the
	// spare address must ignore writes.
	localparam logic [APB_ADDR_W-1:0] ADDR_HIT_THRESHOLD = 3'd0;
	localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = 3'd4;
	localparam int DIST_LIMIT = 131071;
	localparam int DRAIN_CYCLES = 70;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PER_PHASE = 208;

	typedef struct {
		logic [DIST_W-1:0] distance;
		logic              hit;
	} result_t;

	// One row of the directed table. When known is set, the expected result
	// is typed in; otherwise the distance predictor supplies it.
	typedef struct {
		logic               kind;
		logic signed [15:0] px, py, sx, sy, ex, ey, cx, cy;
		bit                 known;
		int                 distance;
		logic               hit;
	} edge_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// point_x, point_y, start_x, start_y, end_x, end_y, center_x, center_y
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// kind
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// distance [16:0], hit [17], zero pad [23:18]
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	result_t         pending_results[$];
	logic [THR_W-1:0] model_threshold = THR_RESET;
	int              error_count = 0;
	int              idle_cycles = 0;
	int              stall_left = 0;
	bit              calm = 1'b0;

	edge_hit_distance_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Is q an upper bound of the distance being searched for? Point mode
	// tests q >= sqrt(x), perpendicular mode q >= y / sqrt(x), and arc mode
	// q >= sqrt(x) - sqrt(y). Products are taken at 128 bits so nothing wraps.
	function automatic bit is_upper_bound(mode_t mode, longint unsigned q,
			longint unsigned x, longint unsigned y);
		longint unsigned q2;
		longint          gap;
		logic [127:0]    lhs, rhs;
		q2 = q * q;
		case (mode)
			MODE_POINT: return q2 >= x;
			MODE_PERP: begin
				lhs = 128'(q2) * 128'(x);
				rhs = 128'(y) * 128'(y);
				return lhs >= rhs;
			end
			default: begin
				gap = longint'(x) - longint'(y) - longint'(q2);
				if (gap <= 0)
					return 1'b1;
				lhs = 128'(4 * q2) * 128'(y);
				rhs = 128'(gap) * 128'(gap);
				return lhs >= rhs;
			end
		endcase
	endfunction

	// Distance from the query point to the edge, rounded up to the next Q.4
	// step, found by bisection over the whole output range.
	function automatic logic [DIST_W-1:0] edge_distance(logic kind,
			logic signed [15:0] px, py, sx, sy, ex, ey, cx, cy);
		longint          abx, aby, apx, apy, ab2, dot, cross_ab;
		longint unsigned x, y, lo, hi, mid;
		mode_t           mode;
		if (!kind) begin
			abx = ex - sx;
			aby = ey - sy;
			apx = px - sx;
			apy = py - sy;
			ab2 = abx * abx + aby * aby;
			dot = apx * abx + apy * aby;
			y = 0;
			if (dot <= 0) begin
				// Projection at or before the start; a zero-length
				// segment also lands here.
				mode = MODE_POINT;
				x = apx * apx + apy * apy;
			end else if (dot >= ab2) begin
				mode = MODE_POINT;
				x = (px - ex) * (px - ex) + (py - ey) * (py - ey);
			end else begin
				mode = MODE_PERP;
				cross_ab = abx * apy - aby * apx;
				x = ab2;
				y = cross_ab < 0 ? -cross_ab : cross_ab;
			end
		end else begin
			mode = MODE_ARC;
			x = (px - cx) * (px - cx) + (py - cy) * (py - cy);
			y = (sx - cx) * (sx - cx) + (sy - cy) * (sy - cy);
			if (x < y) begin
				lo = x;
				x = y;
				y = lo;
			end
		end
		lo = 0;
		hi = DIST_LIMIT;
		while (lo < hi) begin
			mid = (lo + hi) >> 1;
			if (is_upper_bound(mode, mid, x, y))
				hi = mid;
			else
				lo = mid + 1;
		end
		return lo[DIST_W-1:0];
	endfunction

	// Present one edge word, wait for its acceptance, then queue the result
	// it must produce. A random gap may come first while idling is allowed.
	task automatic send_edge(edge_row_t row);
		result_t want;
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= row.kind;
		s_tdata <= {row.cy, row.cx, row.ey, row.ex, row.sy, row.sx, row.py, row.px};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (row.known) begin
			want.distance = row.distance[DIST_W-1:0];
			want.hit = row.hit;
		end else begin
			want.distance = edge_distance(row.kind, row.px, row.py, row.sx, row.sy,
				row.ex, row.ey, row.cx, row.cy);
			want.hit = want.distance <= model_threshold;
		end
		pending_results = {pending_results, want};
	endtask

	// Let the pipeline empty before a register write.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: a setup phase, then an access phase; pready is always high,
	// so the register takes the value at the edge that closes the access.
	task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_HIT_THRESHOLD)
			model_threshold = data[THR_W-1:0];
	endtask

	// A coordinate near a base point, so that many distances stay small and
	// hits occur; now and then a corner value or a fully random value.
	function automatic logic signed [15:0] near_coord(logic signed [15:0] base);
		logic [15:0] corners[4];
		corners = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
		case ($urandom_range(0, 11))
			0: return corners[$urandom_range(0, 3)];
			1, 2: return $urandom;
			default: return base + 16'($urandom_range(0, 1023)) - 16'sd512;
		endcase
	endfunction

	task automatic send_random_edges(int count);
		edge_row_t        row;
		logic signed [15:0] base_x, base_y;
		repeat (count) begin
			base_x = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
			base_y = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
			row.kind = $urandom_range(0, 1);
			row.px = near_coord(base_x);
			row.py = near_coord(base_y);
			row.sx = near_coord(base_x);
			row.sy = near_coord(base_y);
			row.ex = near_coord(base_x);
			row.ey = near_coord(base_y);
			row.cx = near_coord(base_x);
			row.cy = near_coord(base_y);
			// Zero-length segments and zero-radius arcs show up now and then.
			if ($urandom_range(0, 9) == 0) begin
				row.ex = row.sx;
				row.ey = row.sy;
				row.cx = row.sx;
				row.cy = row.sy;
			end
			row.known = 1'b0;
			send_edge(row);
		end
	endtask

	// Result side: check each accepted word against the oldest expectation,
	// and stall m_tready in random bursts while idling is allowed.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, m_tdata);
					error_count++;
				end else begin
					if (m_tdata[DIST_W-1:0] !== pending_results[0].distance) begin
						$display("%0t: distance expected %0d actual %0d", $time,
							pending_results[0].distance, m_tdata[DIST_W-1:0]);
						error_count++;
					end
					if (m_tdata[DIST_W] !== pending_results[0].hit) begin
						$display("%0t: hit expected %b actual %b", $time,
							pending_results[0].hit, m_tdata[DIST_W]);
						error_count++;
					end
					void'(pending_results.pop_front());
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 14);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: too many cycles in a row without a word moving on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("tb_edge_hit_distance_top NOT OK");
			$finish;
		end
	end

	initial begin
		// Directed edges checked at the reset threshold of 10 pixels. The
		// segment runs along x from the origin to 10 px unless noted.
		edge_row_t directed[16] = '{
			// Point on the start of a segment.
			'{0, 0, 0, 0, 0, 160, 0, 0, 0, 1, 0, 1},
			// Zero-length segment: distance to the start.
			'{0, 48, 64, 0, 0, 0, 0, 0, 0, 1, 80, 1},
			// Projection before the start.
			'{0, -48, 64, 0, 0, 160, 0, 0, 0, 1, 80, 1},
			// Projection past the end.
			'{0, 208, 64, 0, 0, 160, 0, 0, 0, 1, 80, 1},
			// Perpendicular distance exactly at the threshold, then one step over.
			'{0, 80, 160, 0, 0, 160, 0, 0, 0, 1, 160, 1},
			'{0, 80, 161, 0, 0, 160, 0, 0, 0, 1, 161, 0},
			// Center fields must not affect a segment.
			'{0, 80, 160, 0, 0, 160, 0, -32768, -32768, 1, 160, 1},
			// Arc: point at the center, radius 1 px.
			'{1, 0, 0, 16, 0, 0, 0, 0, 0, 1, 16, 1},
			// Degenerate arc: start on the center.
			'{1, 80, 96, 32, 32, 0, 0, 32, 32, 1, 80, 1},
			// Point on the circle; end fields must not affect an arc.
			'{1, 320, 0, 0, 320, -1, 32767, 0, 0, 1, 0, 1},
			// Point outside the circle.
			'{1, 0, -480, 0, 160, 0, 0, 0, 0, 1, 320, 0},
			// Long vertical segment with an exact perpendicular distance.
			'{0, -32768, 0, 0, -32768, 0, 32767, 0, 0, 1, 32768, 0},
			// Corner coordinates, predicted.
			'{0, -32768, -32768, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0},
			'{0, 32767, -32768, -32768, -32768, 32767, 32767, 0, 0, 0, 0, 0},
			'{1, -32768, 32767, 32767, 32767, 0, 0, -32768, -32768, 0, 0, 0},
			'{1, -32768, 32767, 32767, -32768, 0, 0, 32767, -32768, 0, 0, 0}
		};
		logic [THR_W-1:0] thresholds[4];

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_edge(directed[i]);
		send_random_edges(RANDOM_PER_PHASE / 2);

		// Each later phase runs under a new threshold: both extremes, a random
		// value and finally the reset value again, without any idling.
		thresholds = '{16'd0, 16'hffff, 16'($urandom), THR_RESET};
		foreach (thresholds[i]) begin
			drain();
			// The spare address must be ignored by the block.
			apb_write(ADDR_SPARE, $urandom);
			apb_write(ADDR_HIT_THRESHOLD, {16'($urandom), thresholds[i]});
			calm = (i == 3);
			send_random_edges(RANDOM_PER_PHASE);
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_edge_hit_distance_top OK");
		else
			$display("tb_edge_hit_distance_top NOT OK");
		$finish;
	end

endmodule
